// ===== design/mmg_pkg.sv =====
// mmg_pkg: shared types, codes and float helpers for the macrocell min/max grid
// used by the controller, the datapath, the top level and the checker
`timescale 1ns / 1ps

package mmg_pkg;

   // command codes of an input item
   typedef enum logic [1:0] {
      CMD_SAMPLE  = 2'd0,
      CMD_READ    = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_code_type;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      REG_SIZE_X    = 2'd0,
      REG_SIZE_Y    = 2'd1,
      REG_SIZE_Z    = 2'd2,
      REG_CELL_SIZE = 2'd3
   } reg_index_type;

   // result status codes
   localparam logic [2:0] STS_ACCEPTED  = 3'd0;
   localparam logic [2:0] STS_DROPPED   = 3'd1;
   localparam logic [2:0] STS_READ_OK   = 3'd2;
   localparam logic [2:0] STS_READ_BAD  = 3'd3;
   localparam logic [2:0] STS_RESTARTED = 3'd4;

   // empty range markers
   localparam logic [31:0] POS_INF_BITS = 32'h7F80_0000;
   localparam logic [31:0] NEG_INF_BITS = 32'hFF80_0000;

   // payload widths
   localparam int REQ_W = 48;
   localparam int RSP_W = 72;

   // controller to datapath
   typedef struct packed {
      logic setup_step;
      logic prod_xy;
      logic prod_xyz;
      logic capture;
      logic calc;
      logic lookup;
      logic commit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic setup_done;
      logic out_free;
   } ctrl_stat_type;

   // monotone integer key of a float bit pattern, -0 below +0
   function automatic logic [31:0] order_key(input logic [31:0] b);
      return b[31] ? ~b : (b | 32'h8000_0000);
   endfunction

   function automatic logic is_nan(input logic [31:0] b);
      return b[30:0] > POS_INF_BITS[30:0];
   endfunction

endpackage

// ===== design/mmg_ctrl.sv =====
// mmg_ctrl: sequencer for grid setup and the per-item phases
// depends on mmg_pkg
`timescale 1ns / 1ps

module mmg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  mmg_pkg::ctrl_stat_type stat,
   output mmg_pkg::ctrl_cmd_type  cmd
);
   import mmg_pkg::*;

   typedef enum logic [6:0] {
      ST_SETUP  = 7'b0000001,
      ST_PROD1  = 7'b0000010,
      ST_PROD2  = 7'b0000100,
      ST_IDLE   = 7'b0001000,
      ST_CALC   = 7'b0010000,
      ST_LOOK   = 7'b0100000,
      ST_COMMIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SETUP:  if (stat.setup_done) state_in = ST_PROD1;
         ST_PROD1:  state_in = ST_PROD2;
         ST_PROD2:  state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid) state_in = ST_CALC;
         ST_CALC:   state_in = ST_LOOK;
         ST_LOOK:   state_in = ST_COMMIT;
         ST_COMMIT: if (stat.out_free) state_in = ST_IDLE;
         default:   state_in = ST_SETUP;
      endcase
      if (csr_we) state_in = ST_SETUP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SETUP;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   assign req_tready     = (state_ff == ST_IDLE);
   assign cmd.setup_step = (state_ff == ST_SETUP);
   assign cmd.prod_xy    = (state_ff == ST_PROD1);
   assign cmd.prod_xyz   = (state_ff == ST_PROD2);
   assign cmd.capture    = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.calc       = (state_ff == ST_CALC);
   assign cmd.lookup     = (state_ff == ST_LOOK);
   assign cmd.commit     = (state_ff == ST_COMMIT) && stat.out_free;

endmodule

// ===== design/mmg_datapath.sv =====
// mmg_datapath: registers, grid extents, position counters, cell store and output item
// depends on mmg_pkg; driven by mmg_ctrl
`timescale 1ns / 1ps

module mmg_datapath #(
   parameter int MAX_CELLS     = 4096,
   parameter int MAX_EDGE      = 1024,
   parameter int MAX_CELL_SIZE = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [10:0]                 csr_wdata,
   input  logic [mmg_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [mmg_pkg::RSP_W-1:0]   rsp_tdata,
   input  mmg_pkg::ctrl_cmd_type       cmd,
   output mmg_pkg::ctrl_stat_type      stat
);
   import mmg_pkg::*;

   localparam int SZ_W  = $clog2(MAX_EDGE + 1);
   localparam int POS_W = (MAX_EDGE > 1) ? $clog2(MAX_EDGE) : 1;
   localparam int CS_W  = $clog2(MAX_CELL_SIZE + 1);
   localparam int OFF_W = (MAX_CELL_SIZE > 1) ? $clog2(MAX_CELL_SIZE) : 1;
   localparam int ACC_W = $clog2(MAX_EDGE + MAX_CELL_SIZE + 1);
   localparam int AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int IDX_W = 3 * SZ_W + 18;

   // configuration registers
   logic [10:0] size_ff [3];
   logic [8:0]  cs_reg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff[0] <= 11'd64;
         size_ff[1] <= 11'd64;
         size_ff[2] <= 11'd64;
         cs_reg_ff  <= 9'd32;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_SIZE_X:    size_ff[0] <= csr_wdata;
            REG_SIZE_Y:    size_ff[1] <= csr_wdata;
            REG_SIZE_Z:    size_ff[2] <= csr_wdata;
            REG_CELL_SIZE: cs_reg_ff  <= csr_wdata[8:0];
            default:       cs_reg_ff  <= cs_reg_ff;
         endcase
      end
   end

   // clamped extents
   logic [SZ_W-1:0] size_c [3];
   logic [CS_W-1:0] cs;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (size_ff[a] == 11'd0) size_c[a] = SZ_W'(1);
         else if (32'(size_ff[a]) > 32'(MAX_EDGE)) size_c[a] = SZ_W'(MAX_EDGE);
         else size_c[a] = SZ_W'(size_ff[a]);
      end
      if (cs_reg_ff == 9'd0) cs = CS_W'(1);
      else if (32'(cs_reg_ff) > 32'(MAX_CELL_SIZE)) cs = CS_W'(MAX_CELL_SIZE);
      else cs = CS_W'(cs_reg_ff);
   end

   // grid extents by repeated addition of the cell size
   logic [ACC_W-1:0]  acc_ff [3];
   logic [SZ_W-1:0]   grid_ff [3];
   logic [2*SZ_W-1:0] gxy_ff;
   logic [3*SZ_W-1:0] total_ff;
   logic              setup_done;

   always_comb begin
      setup_done = 1'b1;
      for (int a = 0; a < 3; a++) begin
         if (acc_ff[a] < ACC_W'(size_c[a])) setup_done = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         for (int a = 0; a < 3; a++) begin
            acc_ff[a]  <= '0;
            grid_ff[a] <= '0;
         end
      end else if (cmd.setup_step) begin
         for (int a = 0; a < 3; a++) begin
            if (acc_ff[a] < ACC_W'(size_c[a])) begin
               acc_ff[a]  <= acc_ff[a] + ACC_W'(cs);
               grid_ff[a] <= grid_ff[a] + SZ_W'(1);
            end
         end
      end
   end

   // grid products
   always_ff @(posedge clock) begin
      if (cmd.prod_xy) gxy_ff <= grid_ff[0] * grid_ff[1];
      if (cmd.prod_xyz) total_ff <= gxy_ff * grid_ff[2];
   end

   // captured item
   logic [1:0]  cmd_ff;
   logic [31:0] sample_ff;
   logic [11:0] ci_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff    <= req_tdata[1:0];
         sample_ff <= req_tdata[33:2];
         ci_ff     <= req_tdata[45:34];
      end
   end

   // position counters
   logic [POS_W-1:0] pos_ff [3], pos_in [3];
   logic [OFF_W-1:0] off_ff [3], off_in [3];
   logic [POS_W-1:0] cc_ff  [3], cc_in  [3];
   logic             done_ff, done_in;

   // index products
   logic [POS_W+SZ_W-1:0]   p1_ff;
   logic [POS_W+2*SZ_W-1:0] p2_ff;

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         p1_ff <= cc_ff[1] * grid_ff[0];
         p2_ff <= cc_ff[2] * gxy_ff;
      end
   end

   // lookup: index, range checks and store read
   logic [IDX_W-1:0] idx;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    addr_ff;
   logic             voxel_in_ff;
   logic             read_ok_ff;
   logic [63:0]      rd_data_ff;
   logic [63:0]      mem [MAX_CELLS];

   assign idx     = IDX_W'(cc_ff[0]) + IDX_W'(p1_ff) + IDX_W'(p2_ff);
   assign rd_addr = (cmd_code_type'(cmd_ff) == CMD_READ) ? AW'(ci_ff) : AW'(idx);

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         addr_ff     <= rd_addr;
         voxel_in_ff <= idx < IDX_W'(MAX_CELLS);
         read_ok_ff  <= done_ff && (64'(ci_ff) < 64'(total_ff))
                        && (32'(ci_ff) < 32'(MAX_CELLS));
         rd_data_ff  <= mem[rd_addr];
      end
   end

   // counter step for one voxel
   logic [POS_W:0] pos_inc;
   logic [OFF_W:0] off_inc;
   logic [2:0]     wrap;
   logic [2:0]     en;

   // range update
   logic        first, nan, wr_en;
   logic [31:0] lo_old, hi_old, lo_new, hi_new;
   logic [31:0] out_lo, out_hi;
   logic [2:0]  out_sts;

   always_comb begin
      pos_in  = pos_ff;
      off_in  = off_ff;
      cc_in   = cc_ff;
      done_in = done_ff;
      wrap    = '0;
      en      = '0;
      pos_inc = '0;
      off_inc = '0;
      wr_en   = 1'b0;
      out_lo  = '0;
      out_hi  = '0;
      out_sts = STS_DROPPED;

      lo_old = rd_data_ff[31:0];
      hi_old = rd_data_ff[63:32];
      first  = (off_ff[0] == '0) && (off_ff[1] == '0) && (off_ff[2] == '0);
      nan    = is_nan(sample_ff);
      if (first) begin
         lo_new = nan ? POS_INF_BITS : sample_ff;
         hi_new = nan ? NEG_INF_BITS : sample_ff;
      end else begin
         lo_new = lo_old;
         hi_new = hi_old;
         if (!nan) begin
            if (order_key(sample_ff) < order_key(lo_old)) lo_new = sample_ff;
            if (order_key(sample_ff) > order_key(hi_old)) hi_new = sample_ff;
         end
      end

      case (cmd_code_type'(cmd_ff))
         CMD_SAMPLE: begin
            if (!done_ff) begin
               wr_en   = voxel_in_ff;
               out_sts = voxel_in_ff ? STS_ACCEPTED : STS_DROPPED;
               en[0]   = 1'b1;
               for (int a = 0; a < 3; a++) begin
                  pos_inc = (POS_W + 1)'(pos_ff[a]) + 1'b1;
                  off_inc = (OFF_W + 1)'(off_ff[a]) + 1'b1;
                  wrap[a] = 32'(pos_inc) >= 32'(size_c[a]);
                  if (a > 0) en[a] = en[a-1] && wrap[a-1];
                  if (en[a]) begin
                     if (wrap[a]) begin
                        pos_in[a] = '0;
                        off_in[a] = '0;
                        cc_in[a]  = '0;
                     end else begin
                        pos_in[a] = POS_W'(pos_inc);
                        if (32'(off_inc) == 32'(cs)) begin
                           off_in[a] = '0;
                           cc_in[a]  = cc_ff[a] + 1'b1;
                        end else begin
                           off_in[a] = OFF_W'(off_inc);
                        end
                     end
                  end
               end
               if (en[2] && wrap[2]) done_in = 1'b1;
            end
         end
         CMD_READ: begin
            if (read_ok_ff) begin
               out_lo  = lo_old;
               out_hi  = hi_old;
               out_sts = STS_READ_OK;
            end else begin
               out_sts = STS_READ_BAD;
            end
         end
         CMD_RESTART: begin
            for (int a = 0; a < 3; a++) begin
               pos_in[a] = '0;
               off_in[a] = '0;
               cc_in[a]  = '0;
            end
            done_in = 1'b0;
            out_sts = STS_RESTARTED;
         end
         default: out_sts = STS_DROPPED;
      endcase
   end

   // counter registers; any register write restarts the brick
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         for (int a = 0; a < 3; a++) begin
            pos_ff[a] <= '0;
            off_ff[a] <= '0;
            cc_ff[a]  <= '0;
         end
         done_ff <= 1'b0;
      end else if (cmd.commit) begin
         pos_ff  <= pos_in;
         off_ff  <= off_in;
         cc_ff   <= cc_in;
         done_ff <= done_in;
      end
   end

   // cell store write
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) mem[addr_ff] <= {hi_new, lo_new};
   end

   // output item register
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_data_ff <= {4'd0, done_in, out_sts, out_hi, out_lo};
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign stat.setup_done = setup_done;
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

endmodule

// ===== design/macrocell_minmax_grid_unit.sv =====
// macrocell_minmax_grid_unit: top level of the macrocell min/max grid builder
// depends on mmg_pkg, mmg_ctrl and mmg_datapath
`timescale 1ns / 1ps

// Voxels of a brick stream in raster order (x fastest) and each cell of
// cell_size^3 voxels keeps its min and max float in an on-chip store of
// MAX_CELLS entries. Every item goes through accept, index products,
// store read, and update and write-back, one item at a time; the output item
// register frees the next accept while a result waits to be taken. After
// reset and after every register write the grid extents are found by
// repeated addition of the cell size, followed by the grid products;
// req_tready stays low meanwhile. A register write also restarts the brick
// but keeps the store.
module macrocell_minmax_grid_unit #(
   parameter int MAX_CELLS     = 4096,
   parameter int MAX_EDGE      = 1024,
   parameter int MAX_CELL_SIZE = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   // csr port
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [10:0]               csr_wdata,
   // input items
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [mmg_pkg::REQ_W-1:0] req_tdata,   // command[1:0], sample[33:2], cell_index[45:34]
   // result items
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [mmg_pkg::RSP_W-1:0] rsp_tdata    // range_low[31:0], range_high[63:32],
                                                  // status[66:64], brick_done[67]
);
   import mmg_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   mmg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mmg_datapath #(
      .MAX_CELLS     (MAX_CELLS),
      .MAX_EDGE      (MAX_EDGE),
      .MAX_CELL_SIZE (MAX_CELL_SIZE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// ===== design/mmg_checker.sv =====
// mmg_checker: port-level checks of the macrocell min/max grid unit
// depends on mmg_pkg; bound to macrocell_minmax_grid_unit
`timescale 1ns / 1ps

module mmg_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [mmg_pkg::RSP_W-1:0] rsp_tdata
);
   import mmg_pkg::*;

   // a waiting result item is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item withdrawn before taken");

   // status codes stay in range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[66:64] <= STS_RESTARTED)
      else $error("status code out of range");

   // only a good read carries ranges
   a_zero_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[66:64] != STS_READ_OK |-> rsp_tdata[63:0] == 64'd0)
      else $error("nonzero range outside a good read");

   // a good read only after the brick is complete
   a_read_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[66:64] == STS_READ_OK |-> rsp_tdata[67])
      else $error("good read before brick done");

   // restart clears brick done
   a_restart_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[66:64] == STS_RESTARTED |-> !rsp_tdata[67])
      else $error("brick done set after restart");

endmodule

bind macrocell_minmax_grid_unit mmg_checker u_mmg_checker (.*);

// ===== test/tb_macrocell_minmax_grid_unit.sv =====
// tb_macrocell_minmax_grid_unit: self-checking testbench of the macrocell min/max grid
// depends on mmg_pkg and macrocell_minmax_grid_unit; predicts each result item in place
`timescale 1ns / 1ps

module tb_macrocell_minmax_grid_unit;
   import mmg_pkg::*;

   localparam int NUM_CELLS  = 4096;
   localparam int EDGE_MAX   = 1024;
   localparam int CELL_MAX   = 256;
   localparam int WDOG_LIMIT = 20000;
   localparam int DRAIN_WAIT = 12;

   // one result item
   typedef struct packed {
      logic [31:0] lo;
      logic [31:0] hi;
      logic [2:0]  status;
      logic        done;
   } grid_rsp_t;

   // one row of the directed table: a register write or an item
   typedef struct {
      logic          is_cfg;
      reg_index_type cfg_idx;
      logic [10:0]   cfg_val;
      cmd_code_type  cmd;
      logic [31:0]   sample;
      logic [11:0]   ci;
      logic          typed;
      grid_rsp_t     rsp;
   } stim_row_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [1:0]          csr_index = '0;
   logic [10:0]         csr_wdata = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;

   macrocell_minmax_grid_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // predictor state
   logic [31:0] cell_lo [NUM_CELLS];
   logic [31:0] cell_hi [NUM_CELLS];
   int          vox_pos [3];
   int          vox_off [3];
   int          cell_pos [3];
   logic        brick_full;
   int          reg_size [3];
   int          reg_cell;

   grid_rsp_t   pending_ranges [$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          error_count = 0;
   int          item_count = 0;
   int          rsp_count = 0;
   int          read_ok_count = 0;
   int          drop_count = 0;
   int          brick_count = 0;
   int          stall_cycles = 0;

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int clamp_to(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int grid_dim(input int axis);
      int ext;
      int cs;
      ext = clamp_to(reg_size[axis], EDGE_MAX);
      cs = clamp_to(reg_cell, CELL_MAX);
      return (ext + cs - 1) / cs;
   endfunction

   function automatic longint grid_cells();
      return longint'(grid_dim(0)) * grid_dim(1) * grid_dim(2);
   endfunction

   function automatic logic [31:0] float_key(input logic [31:0] b);
      return b[31] ? ~b : {1'b1, b[30:0]};
   endfunction

   function automatic void restart_counters();
      for (int a = 0; a < 3; a++) begin
         vox_pos[a] = 0;
         vox_off[a] = 0;
         cell_pos[a] = 0;
      end
      brick_full = 1'b0;
   endfunction

   function automatic void apply_register(input reg_index_type idx, input logic [10:0] val);
      case (idx)
         REG_SIZE_X:    reg_size[0] = int'(val);
         REG_SIZE_Y:    reg_size[1] = int'(val);
         REG_SIZE_Z:    reg_size[2] = int'(val);
         REG_CELL_SIZE: reg_cell = int'(val[8:0]);
         default: ;
      endcase
      restart_counters();
   endfunction

   // expected result of one item, updates the predicted grid
   function automatic grid_rsp_t predict_cell_range(input cmd_code_type cmd,
                                                    input logic [31:0] s,
                                                    input logic [11:0] ci);
      grid_rsp_t r;
      int        cs;
      longint    gx;
      longint    gy;
      longint    idx;
      logic      nan;
      logic      carry;
      r = '0;
      r.status = STS_DROPPED;
      cs = clamp_to(reg_cell, CELL_MAX);
      gx = grid_dim(0);
      gy = grid_dim(1);
      case (cmd)
         CMD_SAMPLE: begin
            if (!brick_full) begin
               idx = cell_pos[0] + cell_pos[1] * gx + cell_pos[2] * gx * gy;
               if (idx < NUM_CELLS) begin
                  nan = (s[30:0] > 31'h7F80_0000);
                  if (vox_off[0] == 0 && vox_off[1] == 0 && vox_off[2] == 0) begin
                     cell_lo[idx] = nan ? POS_INF_BITS : s;
                     cell_hi[idx] = nan ? NEG_INF_BITS : s;
                  end else if (!nan) begin
                     if (float_key(s) < float_key(cell_lo[idx])) cell_lo[idx] = s;
                     if (float_key(s) > float_key(cell_hi[idx])) cell_hi[idx] = s;
                  end
                  r.status = STS_ACCEPTED;
               end
               // raster counters, x fastest
               carry = 1'b1;
               for (int a = 0; a < 3 && carry; a++) begin
                  vox_pos[a]++;
                  vox_off[a]++;
                  if (vox_off[a] == cs) begin
                     vox_off[a] = 0;
                     cell_pos[a]++;
                  end
                  if (vox_pos[a] >= clamp_to(reg_size[a], EDGE_MAX)) begin
                     vox_pos[a] = 0;
                     vox_off[a] = 0;
                     cell_pos[a] = 0;
                  end else begin
                     carry = 1'b0;
                  end
               end
               if (carry) brick_full = 1'b1;
            end
         end
         CMD_READ: begin
            if (brick_full && longint'(ci) < grid_cells()) begin
               r.lo = cell_lo[ci];
               r.hi = cell_hi[ci];
               r.status = STS_READ_OK;
            end else begin
               r.status = STS_READ_BAD;
            end
         end
         CMD_RESTART: begin
            restart_counters();
            r.status = STS_RESTARTED;
         end
         default: ;
      endcase
      r.done = brick_full;
      return r;
   endfunction

   // register write once the block has gone quiet
   task automatic write_register(input reg_index_type idx, input logic [10:0] val);
      req_tvalid <= 1'b0;
      while (pending_ranges.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_register(idx, val);
   endtask

   task automatic configure_brick(input int sx, input int sy, input int sz, input int cs);
      write_register(REG_SIZE_X, 11'(sx));
      write_register(REG_SIZE_Y, 11'(sy));
      write_register(REG_SIZE_Z, 11'(sz));
      write_register(REG_CELL_SIZE, 11'(cs));
      brick_count++;
   endtask

   // send one item; a typed expectation replaces the predicted one
   task automatic send_item(input cmd_code_type cmd, input logic [31:0] s,
                            input logic [11:0] ci, input logic typed,
                            input grid_rsp_t typed_rsp);
      grid_rsp_t r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, ci, s, cmd};
      do @(posedge clock); while (!req_tready);
      r = predict_cell_range(cmd, s, ci);
      pending_ranges.push_back(typed ? typed_rsp : r);
      item_count++;
   endtask

   function automatic logic [31:0] random_sample();
      case ($urandom_range(9))
         0: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
         1: return {1'($urandom_range(1)), 31'h0};
         2: return {1'($urandom_range(1)), 31'h7F80_0000};
         3: return {1'($urandom_range(1)), 8'($urandom_range(120, 133)), 23'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // one brick with random content, noise items mixed in, reads at the end
   task automatic stream_brick(input int noise_pct);
      int        pick;
      int        ncells;
      grid_rsp_t none;
      none = '0;
      ncells = (grid_cells() > NUM_CELLS) ? NUM_CELLS : int'(grid_cells());
      while (!brick_full) begin
         pick = $urandom_range(99);
         if (pick >= noise_pct) begin
            send_item(CMD_SAMPLE, random_sample(), '0, 1'b0, none);
         end else if (pick % 4 == 0) begin
            send_item(CMD_UNUSED, $urandom, 12'($urandom), 1'b0, none);
         end else if (pick % 17 == 1) begin
            send_item(CMD_RESTART, $urandom, 12'($urandom), 1'b0, none);
         end else begin
            send_item(CMD_READ, $urandom, 12'($urandom_range(0, ncells)), 1'b0, none);
         end
      end
      send_item(CMD_SAMPLE, random_sample(), 12'($urandom), 1'b0, none);
      repeat ($urandom_range(3, 7)) begin
         if ($urandom_range(5) == 0)
            send_item(CMD_READ, $urandom, 12'($urandom), 1'b0, none);
         else
            send_item(CMD_READ, $urandom, 12'($urandom_range(0, ncells)), 1'b0, none);
      end
   endtask

   // result side: random stalls and in-order checking
   always @(posedge clock) begin
      grid_rsp_t got;
      grid_rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.lo = rsp_tdata[31:0];
         got.hi = rsp_tdata[63:32];
         got.status = rsp_tdata[66:64];
         got.done = rsp_tdata[67];
         rsp_count++;
         if (got.status == STS_READ_OK) read_ok_count++;
         if (got.status == STS_DROPPED) drop_count++;
         if (pending_ranges.size() == 0) begin
            $error("result item with nothing expected: %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_ranges.pop_front();
            if (got.lo !== want.lo) begin
               $error("range_low expected %h got %h", want.lo, got.lo);
               error_count++;
            end
            if (got.hi !== want.hi) begin
               $error("range_high expected %h got %h", want.hi, got.hi);
               error_count++;
            end
            if (got.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, got.status);
               error_count++;
            end
            if (got.done !== want.done) begin
               $error("brick_done expected %0d got %0d", want.done, got.done);
               error_count++;
            end
            if (rsp_tdata[RSP_W-1:68] !== '0) begin
               $error("rsp pad expected 0 got %h", rsp_tdata[RSP_W-1:68]);
               error_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // directed table
   stim_row_t directed [] = '{
      '{0, REG_SIZE_X, 0, CMD_READ, 32'h0, 12'd0, 1, '{32'h0, 32'h0, STS_READ_BAD, 1'b0}},
      '{0, REG_SIZE_X, 0, CMD_UNUSED, 32'hFFFF_FFFF, 12'hFFF, 1,
        '{32'h0, 32'h0, STS_DROPPED, 1'b0}},
      '{0, REG_SIZE_X, 0, CMD_RESTART, 32'h0, 12'd0, 1, '{32'h0, 32'h0, STS_RESTARTED, 1'b0}},
      '{0, REG_SIZE_X, 0, CMD_SAMPLE, 32'h3F80_0000, 12'd0, 0, '0},
      '{1, REG_SIZE_X, 4, CMD_SAMPLE, 32'h0, 12'd0, 0, '0},
      '{1, REG_SIZE_Y, 1, CMD_SAMPLE, 32'h0, 12'd0, 0, '0},
      '{1, REG_SIZE_Z, 1, CMD_SAMPLE, 32'h0, 12'd0, 0, '0},
      '{1, REG_CELL_SIZE, 2, CMD_SAMPLE, 32'h0, 12'd0, 0, '0},
      // first voxel of a cell is NaN, cell holds only NaN
      '{0, REG_SIZE_X, 0, CMD_SAMPLE, 32'h7FC0_0000, 12'd0, 1,
        '{32'h0, 32'h0, STS_ACCEPTED, 1'b0}},
      '{0, REG_SIZE_X, 0, CMD_SAMPLE, 32'hFFFF_FFFF, 12'd0, 0, '0},
      // minus zero sorts below plus zero
      '{0, REG_SIZE_X, 0, CMD_SAMPLE, 32'h0000_0000, 12'd0, 0, '0},
      '{0, REG_SIZE_X, 0, CMD_SAMPLE, 32'h8000_0000, 12'd0, 1,
        '{32'h0, 32'h0, STS_ACCEPTED, 1'b1}},
      // voxel past the end
      '{0, REG_SIZE_X, 0, CMD_SAMPLE, 32'h3F80_0000, 12'd0, 1,
        '{32'h0, 32'h0, STS_DROPPED, 1'b1}},
      '{0, REG_SIZE_X, 0, CMD_READ, 32'h0, 12'd0, 1,
        '{POS_INF_BITS, NEG_INF_BITS, STS_READ_OK, 1'b1}},
      '{0, REG_SIZE_X, 0, CMD_READ, 32'h0, 12'd1, 1,
        '{32'h8000_0000, 32'h0000_0000, STS_READ_OK, 1'b1}},
      '{0, REG_SIZE_X, 0, CMD_READ, 32'h0, 12'd2, 1, '{32'h0, 32'h0, STS_READ_BAD, 1'b1}},
      '{0, REG_SIZE_X, 0, CMD_READ, 32'h0, 12'hFFF, 1, '{32'h0, 32'h0, STS_READ_BAD, 1'b1}},
      '{0, REG_SIZE_X, 0, CMD_RESTART, 32'h0, 12'd0, 1,
        '{32'h0, 32'h0, STS_RESTARTED, 1'b0}},
      // infinities and largest finite, NaN after the first voxel
      '{0, REG_SIZE_X, 0, CMD_SAMPLE, 32'hFF80_0000, 12'd0, 0, '0},
      '{0, REG_SIZE_X, 0, CMD_SAMPLE, 32'h7F80_0000, 12'd0, 0, '0},
      '{0, REG_SIZE_X, 0, CMD_SAMPLE, 32'h7F7F_FFFF, 12'd0, 0, '0},
      '{0, REG_SIZE_X, 0, CMD_SAMPLE, 32'hFFFF_FFFF, 12'd0, 0, '0},
      '{0, REG_SIZE_X, 0, CMD_READ, 32'h0, 12'd0, 0, '0},
      '{0, REG_SIZE_X, 0, CMD_READ, 32'h0, 12'd1, 0, '0}
   };

   // main sequence
   initial begin
      for (int i = 0; i < NUM_CELLS; i++) begin
         cell_lo[i] = '0;
         cell_hi[i] = '0;
      end
      reg_size[0] = 64;
      reg_size[1] = 64;
      reg_size[2] = 64;
      reg_cell = 32;
      restart_counters();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed items
      foreach (directed[i]) begin
         if (directed[i].is_cfg)
            write_register(directed[i].cfg_idx, directed[i].cfg_val);
         else
            send_item(directed[i].cmd, directed[i].sample, directed[i].ci,
                      directed[i].typed, directed[i].rsp);
      end

      // random bricks under three idle patterns
      while (item_count < 400) begin
         if (item_count < 140) begin
            send_idle_pct = 27;
            recv_idle_pct = 48;
         end else if (item_count < 280) begin
            send_idle_pct = 48;
            recv_idle_pct = 27;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         configure_brick($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 4),
                         $urandom_range(1, 4));
         stream_brick(12);
      end

      // extreme settings: clamped sizes and largest cell, then a zero cell size
      configure_brick(2047, 1, 0, 511);
      stream_brick(0);
      configure_brick(3, 2, 1, 0);
      stream_brick(0);

      req_tvalid <= 1'b0;
      while (pending_ranges.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d items over %0d bricks, %0d results, %0d good reads, %0d drops",
               item_count, brick_count, rsp_count, read_ok_count, drop_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/mmg_pkg.sv
design/mmg_ctrl.sv
design/mmg_datapath.sv
design/macrocell_minmax_grid_unit.sv
design/mmg_checker.sv
test/tb_macrocell_minmax_grid_unit.sv
